// ===== hdl/sha256_stream_hasher_defines.svh =====
// assertion macros used by the sha-256 stream hasher checker
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SHAH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SHAH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/shah_pkg.sv =====
// shared constants, types and sigma functions of the sha-256 stream hasher
`timescale 1ns / 1ps

package shah_pkg;

	localparam int unsigned CNT_W = 61;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] K_ROUND [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H_INIT [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_RND0,
		ST_RND1,
		ST_FIN,
		ST_OUT
	} state_t;

	// controls of the block buffer and message schedule
	typedef struct packed {
		logic       push;
		logic [7:0] byte_val;
		logic       step;
	} sched_ctl_t;

	// controls of the round unit and chaining words
	typedef struct packed {
		logic       load;
		logic       ph0;
		logic       ph1;
		logic       fin;
		logic       rot;
		logic       init;
		logic [5:0] rnd;
	} round_ctl_t;

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

// ===== hdl/shah_sched.sv =====
// block buffer as a byte shift line that doubles as the message schedule window
`timescale 1ns / 1ps

module shah_sched (
	input  logic                  clk,
	input  shah_pkg::sched_ctl_t  ctl,
	output logic [31:0]           w_cur
);

	localparam int unsigned WORDS = 16;
	localparam int unsigned BUF_W = WORDS * 32;

	logic [BUF_W-1:0] buf_q;
	logic [31:0]      w_next;

	// word j of the window sits at the top end for j equal to zero
	function automatic logic [31:0] word_at(input logic [BUF_W-1:0] b, input int unsigned j);
		return b[BUF_W-1-32*j -: 32];
	endfunction

	// next schedule word from the sixteen-word window
	always_comb begin
		w_next = shah_pkg::small_sigma1(word_at(buf_q, 14)) + word_at(buf_q, 9)
			+ shah_pkg::small_sigma0(word_at(buf_q, 1)) + word_at(buf_q, 0);
	end

	assign w_cur = word_at(buf_q, 0);

	// bytes enter at the bottom; each round step drops the oldest word
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			buf_q <= {buf_q[BUF_W-9:0], ctl.byte_val};
		end else if (ctl.step) begin
			buf_q <= {buf_q[BUF_W-33:0], w_next};
		end
	end

endmodule

// ===== hdl/shah_round.sv =====
// shared two-phase compression round unit with the chaining words
`timescale 1ns / 1ps

module shah_round (
	input  logic                  clk,
	input  logic                  arst_n,
	input  shah_pkg::round_ctl_t  ctl,
	input  logic [31:0]           w_cur,
	output logic [31:0]           chain_head
);

	logic [31:0] chain_q [0:7];
	logic [31:0] v_q [0:7];
	logic [31:0] hkw_q;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	// second phase of a round: sigma, choose and majority terms
	always_comb begin
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = hkw_q + shah_pkg::big_sigma1(v_q[4]) + ch;
		t2  = shah_pkg::big_sigma0(v_q[0]) + maj;
	end

	assign chain_head = chain_q[0];

	// chaining words: initial value, block sum, rotation while the digest is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= shah_pkg::H_INIT;
		end else begin
			priority if (ctl.init) begin
				chain_q <= shah_pkg::H_INIT;
			end else if (ctl.fin) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
			end else if (ctl.rot) begin
				for (int i = 0; i < 7; i++) begin
					chain_q[i] <= chain_q[i+1];
				end
				chain_q[7] <= chain_q[0];
			end
		end
	end

	// working variables and the first-phase partial sum
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= chain_q;
		end else if (ctl.ph1) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
		if (ctl.ph0) begin
			hkw_q <= v_q[7] + shah_pkg::K_ROUND[ctl.rnd] + w_cur;
		end
	end

endmodule

// ===== hdl/sha256_stream_hasher.sv =====
// top level of the sha-256 stream hasher: sequencer, padding and digest output
// Takes a message one byte per input beat (tuser high marks a data byte, tlast ends the
// message) and returns the eight digest words, H0 first, as eight output beats. A byte
// beat that neither fills the 64-byte block nor ends the message leaves the input ready
// for the next beat. A full block runs through one shared round unit as a load, then the
// rounds in two phases each, then a chaining add, during which the input is held off. The
// end of a message pads byte by byte up to the block end, then runs one or two block
// compressions and eight output beats; the input is not ready again until the last
// digest word has been taken. Bytes past 2^61-1 are dropped and flagged in tuser bit 3.
`timescale 1ns / 1ps

module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] has_byte
	input  logic        s_axis_tlast,  // end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] digest_word
	output logic [3:0]  m_axis_tuser,  // [2:0] word_index, [3] length_error
	output logic        m_axis_tlast   // last_word
);

	shah_pkg::state_t     state_q, state_d;
	logic [5:0]           rnd_q, rnd_d;
	logic [5:0]           pos_q, pos_d;
	logic [shah_pkg::CNT_W-1:0] count_q, count_d;
	logic                 ovf_q, ovf_d;
	logic                 fin_q, fin_d;
	logic                 first_q, first_d;
	logic                 lenok_q, lenok_d;
	logic                 done_q, done_d;
	logic [2:0]           idx_q, idx_d;
	logic                 blk_full;
	logic                 lenok_nx;
	logic [7:0][7:0]      len_bytes;
	logic [31:0]          w_cur;
	logic [31:0]          chain_head;
	shah_pkg::sched_ctl_t sctl;
	shah_pkg::round_ctl_t rctl;

	// big-endian bit length, byte 7 is sent first
	assign len_bytes = {count_q, 3'b000};

	// sequencer: next state and unit controls
	always_comb begin
		state_d       = state_q;
		rnd_d         = rnd_q;
		pos_d         = pos_q;
		count_d       = count_q;
		ovf_d         = ovf_q;
		fin_d         = fin_q;
		first_d       = first_q;
		lenok_d       = lenok_q;
		done_d        = done_q;
		idx_d         = idx_q;
		blk_full      = 1'b0;
		lenok_nx      = lenok_q;
		sctl          = '0;
		rctl          = '0;
		rctl.rnd      = rnd_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		unique case (state_q)
			shah_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (s_axis_tuser) begin
						if (count_q == shah_pkg::COUNT_MAX) begin
							ovf_d = 1'b1;
						end else begin
							sctl.push     = 1'b1;
							sctl.byte_val = s_axis_tdata;
							count_d       = count_q + 1'b1;
							pos_d         = pos_q + 6'd1;
							blk_full      = (pos_q == 6'd63);
						end
					end
					if (s_axis_tlast) begin
						fin_d   = 1'b1;
						first_d = 1'b1;
					end
					if (blk_full) begin
						state_d = shah_pkg::ST_LOAD;
					end else if (s_axis_tlast) begin
						state_d = shah_pkg::ST_PAD;
					end
				end
			end
			shah_pkg::ST_PAD: begin
				lenok_nx  = first_q ? (pos_q[5:3] != 3'd7) : lenok_q;
				sctl.push = 1'b1;
				if (first_q) begin
					sctl.byte_val = shah_pkg::PAD_BYTE;
				end else if (lenok_q && (pos_q[5:3] == 3'd7)) begin
					sctl.byte_val = len_bytes[~pos_q[2:0]];
				end else begin
					sctl.byte_val = 8'h00;
				end
				pos_d   = pos_q + 6'd1;
				first_d = 1'b0;
				lenok_d = lenok_nx;
				if (pos_q == 6'd63) begin
					lenok_d = 1'b1;
					done_d  = lenok_nx;
					state_d = shah_pkg::ST_LOAD;
				end
			end
			shah_pkg::ST_LOAD: begin
				rctl.load = 1'b1;
				rnd_d     = 6'd0;
				state_d   = shah_pkg::ST_RND0;
			end
			shah_pkg::ST_RND0: begin
				rctl.ph0 = 1'b1;
				state_d  = shah_pkg::ST_RND1;
			end
			shah_pkg::ST_RND1: begin
				rctl.ph1  = 1'b1;
				sctl.step = 1'b1;
				rnd_d     = rnd_q + 6'd1;
				state_d   = (rnd_q == 6'd63) ? shah_pkg::ST_FIN : shah_pkg::ST_RND0;
			end
			shah_pkg::ST_FIN: begin
				rctl.fin = 1'b1;
				if (!fin_q) begin
					state_d = shah_pkg::ST_IDLE;
				end else if (done_q) begin
					state_d = shah_pkg::ST_OUT;
				end else begin
					state_d = shah_pkg::ST_PAD;
				end
			end
			shah_pkg::ST_OUT: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) begin
					rctl.rot = 1'b1;
					idx_d    = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						rctl.init = 1'b1;
						count_d   = '0;
						ovf_d     = 1'b0;
						fin_d     = 1'b0;
						done_d    = 1'b0;
						lenok_d   = 1'b0;
						state_d   = shah_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = shah_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shah_pkg::ST_IDLE;
			rnd_q   <= '0;
			pos_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			fin_q   <= 1'b0;
			first_q <= 1'b0;
			lenok_q <= 1'b0;
			done_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			rnd_q   <= rnd_d;
			pos_q   <= pos_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
			fin_q   <= fin_d;
			first_q <= first_d;
			lenok_q <= lenok_d;
			done_q  <= done_d;
			idx_q   <= idx_d;
		end
	end

	// digest beat straight from the chaining register head
	assign m_axis_tdata = chain_head;
	assign m_axis_tuser = {ovf_q, idx_q};
	assign m_axis_tlast = (idx_q == 3'd7);

	shah_sched u_sched (
		.clk   (clk),
		.ctl   (sctl),
		.w_cur (w_cur)
	);

	shah_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (rctl),
		.w_cur      (w_cur),
		.chain_head (chain_head)
	);

endmodule

// ===== hdl/shah_checker.sv =====
// port-level checker of the sha-256 stream hasher, bound to the top level
`timescale 1ns / 1ps
`include "sha256_stream_hasher_defines.svh"

module shah_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// no input beat is taken while a digest is being delivered
	`SHAH_ASSERT_IMP(a_no_overlap, m_axis_tvalid, !s_axis_tready, "input ready during digest")

	// the digest burst runs on until its last word
	`SHAH_ASSERT_NXT(a_burst_on, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tuser[2:0] == $past(m_axis_tuser[2:0]) + 3'd1), "digest burst broken")

	// the burst ends after the last word
	`SHAH_ASSERT_NXT(a_burst_end, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid, "digest burst overrun")

	// last word marks index seven only
	`SHAH_ASSERT_IMP(a_last_idx, m_axis_tvalid, m_axis_tlast == (m_axis_tuser[2:0] == 3'd7), "tlast out of place")

	// a stalled digest beat holds its data
	`SHAH_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")

endmodule

bind sha256_stream_hasher shah_checker u_shah_checker (.*);

// ===== tb/tb_top.sv =====
// self-checking testbench of the sha-256 stream hasher: directed and random messages
`timescale 1ns / 1ps

module tb_top;

	localparam logic [60:0] BYTES_MAX = '1;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int TAIL_CYCLES = 400;
	localparam int DRAIN_LIMIT = 100000;
	// crosses one block boundary and leaves the pad byte at 56, so two closing blocks
	localparam int SPAN_LEN = 120;

	// well-known digests, H0 in the top bits
	localparam logic [255:0] EMPTY_DIGEST =
		256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
	localparam logic [255:0] ABC_DIGEST =
		256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

	localparam logic [31:0] SHA_IV [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// one digest beat as it should leave the block
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
		logic        err;
	} digest_beat_t;

	// one directed input beat, with a typed-in digest where known
	typedef struct packed {
		logic         has;
		logic [7:0]   data;
		logic         eom;
		logic         known;
		logic [255:0] digest;
	} dir_row_t;

	localparam int DIR_ROWS = 11;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{1'b0, 8'hff, 1'b0, 1'b0, 256'd0},        // idle beat straight after reset
		'{1'b0, 8'h00, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message
		'{1'b1, 8'h61, 1'b0, 1'b0, 256'd0},
		'{1'b0, 8'h00, 1'b0, 1'b0, 256'd0},        // idle beat inside a message
		'{1'b1, 8'h62, 1'b0, 1'b0, 256'd0},
		'{1'b1, 8'h63, 1'b1, 1'b1, ABC_DIGEST},    // last byte carries the end
		'{1'b1, 8'h00, 1'b0, 1'b0, 256'd0},
		'{1'b1, 8'hff, 1'b0, 1'b0, 256'd0},
		'{1'b0, 8'h5a, 1'b1, 1'b0, 256'd0},        // end on a beat of its own
		'{1'b1, 8'hff, 1'b1, 1'b0, 256'd0},        // one-byte message
		'{1'b1, 8'h00, 1'b1, 1'b0, 256'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// predictor state
	logic [31:0] sha_chain [0:7];
	logic [7:0]  msg_block [0:63];
	logic [60:0] msg_bytes;
	logic        msg_overflow;

	digest_beat_t digest_q [$];
	int errors = 0;
	logic steady = 1'b0;
	int rx_hold = 0;

	sha256_stream_hasher DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// 64-round compression of the buffered block into the chaining words
	task automatic compress_block();
		logic [31:0] w [0:63];
		logic [31:0] v [0:7];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = sha_chain[i];
		for (int i = 0; i < 64; i++) begin
			s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
			t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
			s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
			t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			sha_chain[i] = sha_chain[i] + v[i];
	endtask

	task automatic restart_hash();
		for (int i = 0; i < 8; i++)
			sha_chain[i] = SHA_IV[i];
		msg_bytes = '0;
		msg_overflow = 1'b0;
	endtask

	// pad byte, zero fill and bit length; one or two closing blocks
	task automatic pad_and_close();
		int pos;
		logic [63:0] bits;
		pos = int'(msg_bytes[5:0]);
		bits = {msg_bytes, 3'b000};
		msg_block[pos] = PAD_MARK;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				msg_block[pos] = 8'h00;
				pos++;
			end
			compress_block();
			pos = 0;
		end
		while (pos < 56) begin
			msg_block[pos] = 8'h00;
			pos++;
		end
		for (int i = 0; i < 8; i++)
			msg_block[63-i] = bits[8*i +: 8];
		compress_block();
	endtask

	// next state and expected digest beats for one accepted input beat
	task automatic predict_beat(input logic has, input logic [7:0] data, input logic eom,
		input logic known, input logic [255:0] ref_digest);
		digest_beat_t b;
		if (has) begin
			if (msg_bytes == BYTES_MAX) begin
				msg_overflow = 1'b1;
			end else begin
				msg_block[msg_bytes[5:0]] = data;
				msg_bytes++;
				if (msg_bytes[5:0] == 6'd0)
					compress_block();
			end
		end
		if (eom) begin
			pad_and_close();
			for (int i = 0; i < 8; i++) begin
				b.word = known ? ref_digest[255-32*i -: 32] : sha_chain[i];
				b.idx = 3'(i);
				b.last = (i == 7);
				b.err = msg_overflow;
				digest_q = {digest_q, b};
			end
			restart_hash();
		end
	endtask

	// drive one input beat from a falling edge and wait for its handshake
	task automatic send_beat(input logic has, input logic [7:0] data, input logic eom,
		input logic known, input logic [255:0] ref_digest);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= has;
		s_axis_tlast <= eom;
		do @(posedge clk); while (!s_axis_tready);
		predict_beat(has, data, eom, known, ref_digest);
		@(negedge clk);
	endtask

	// sender holds off until every pending digest beat has come out
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (digest_q.size() != 0);
	endtask

	// receiver stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_axis_tready <= 1'b1;
			if (!steady)
				rx_hold = pick_gap();
		end
	end

	// digest beat checker
	always @(posedge clk) begin
		digest_beat_t exp_beat;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (digest_q.size() == 0) begin
				errors++;
				$display("%0t: digest beat with none pending, expected nothing actual %h",
					$time, m_axis_tdata);
			end else begin
				exp_beat = digest_q.pop_front();
				if (m_axis_tdata !== exp_beat.word) begin
					errors++;
					$display("%0t: digest word expected %h actual %h",
						$time, exp_beat.word, m_axis_tdata);
				end
				if (m_axis_tuser[2:0] !== exp_beat.idx) begin
					errors++;
					$display("%0t: word index expected %0d actual %0d",
						$time, exp_beat.idx, m_axis_tuser[2:0]);
				end
				if (m_axis_tlast !== exp_beat.last) begin
					errors++;
					$display("%0t: last word expected %b actual %b",
						$time, exp_beat.last, m_axis_tlast);
				end
				if (m_axis_tuser[3] !== exp_beat.err) begin
					errors++;
					$display("%0t: length error expected %b actual %b",
						$time, exp_beat.err, m_axis_tuser[3]);
				end
			end
		end
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// stimulus
	initial begin
		int wait_cnt;
		logic join_end;
		restart_hash();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int r = 0; r < DIR_ROWS; r++)
			send_beat(dir_rows[r].has, dir_rows[r].data, dir_rows[r].eom,
				dir_rows[r].known, dir_rows[r].digest);
		hold_until_drained();

		// random message across a block boundary, end on the last byte or on its own
		join_end = ($urandom_range(1) == 1);
		for (int i = 0; i < SPAN_LEN; i++) begin
			// gapless stretches now and then
			if ((i % 16) == 0)
				steady = ($urandom_range(4) == 0);
			// stray idle beats as noise
			if ($urandom_range(31) == 0)
				send_beat(1'b0, 8'($urandom_range(255)), 1'b0, 1'b0, 256'd0);
			send_beat(1'b1, 8'($urandom_range(255)), join_end && (i == SPAN_LEN - 1),
				1'b0, 256'd0);
		end
		if (!join_end)
			send_beat(1'b0, 8'($urandom_range(255)), 1'b1, 1'b0, 256'd0);
		steady = 1'b0;
		s_axis_tvalid <= 1'b0;

		// drain, then watch for stray beats
		wait_cnt = 0;
		while (digest_q.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);
		if (digest_q.size() != 0) begin
			errors++;
			$display("%0t: %0d digest beats never arrived", $time, digest_q.size());
		end
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/shah_pkg.sv
hdl/shah_sched.sv
hdl/shah_round.sv
hdl/sha256_stream_hasher.sv
hdl/shah_checker.sv
tb/tb_top.sv
